// File: rtl/core/riti_pkg.sv
// Package for the refraction index table interpolator core.
// Holds table sizing, mode and status codes, controller states and control structs.
package riti_pkg;

    localparam int TABLE_DEPTH = 512;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRIES_W   = 10;
    localparam int E_W         = 32;
    localparam int V_W         = 48;
    localparam int MAG_W       = 50;
    localparam int PROD_W      = MAG_W + E_W;
    // set-up steps (operands, low partial product, high partial product)
    // followed by one restoring step per product bit
    localparam int DIV_CYCLES  = PROD_W + 3;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_NOT_INCR = 3'd2,
        ST_FULL     = 3'd3,
        ST_RANGE    = 3'd4,
        ST_EMPTY    = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_PAIR_RD,
        S_PAIR_LAT,
        S_MUL,
        S_DIV,
        S_FIN,
        S_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic decide;
        logic srch_init;
        logic srch_rd;
        logic srch_cmp;
        logic pair_rd;
        logic pair_lat;
        logic mul;
        logic div_step;
        logic fin;
        logic out_valid;
    } cmd_t;

    typedef struct packed {
        logic     query_direct;
        logic     srch_done;
        logic     first_point;
        logic     div_done;
    } sts_t;

endpackage

// File: rtl/core/riti_ctrl.sv
// Controller state machine of the interpolator core.
// Depends on riti_pkg for states and command/status structs.
module riti_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          out_ready,
    input  riti_pkg::sts_t sts,
    output riti_pkg::cmd_t cmd
);
    import riti_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (in_valid) state_next = S_DECIDE;
            S_DECIDE:   state_next = sts.query_direct ? S_SRCH_RD : S_OUT;
            S_SRCH_RD:  state_next = S_SRCH_CMP;
            S_SRCH_CMP: begin
                if (sts.srch_done) begin
                    state_next = sts.first_point ? S_FIN : S_PAIR_RD;
                end else begin
                    state_next = S_SRCH_RD;
                end
            end
            S_PAIR_RD:  state_next = S_PAIR_LAT;
            S_PAIR_LAT: state_next = S_MUL;
            S_MUL:      state_next = S_DIV;
            S_DIV:      if (sts.div_done) state_next = S_FIN;
            S_FIN:      state_next = S_OUT;
            S_OUT:      if (out_ready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        in_ready = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:     cmd.capture = in_valid;
            S_DECIDE: begin
                cmd.decide = 1'b1;
                cmd.srch_init = 1'b1;
            end
            S_SRCH_RD:  cmd.srch_rd = 1'b1;
            S_SRCH_CMP: cmd.srch_cmp = 1'b1;
            S_PAIR_RD:  cmd.pair_rd = 1'b1;
            S_PAIR_LAT: cmd.pair_lat = 1'b1;
            S_MUL:      cmd.mul = 1'b1;
            S_DIV:      cmd.div_step = 1'b1;
            S_FIN:      cmd.fin = 1'b1;
            S_OUT:      cmd.out_valid = 1'b1;
            default:    cmd = '0;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && !out_ready) |=> state_reg == S_OUT)
        else $error("result dropped while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_valid |-> !in_ready)
        else $error("input accepted while result pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && sts.div_done) |=> state_reg == S_FIN)
        else $error("divider completion missed");

endmodule

// File: rtl/core/riti_dp.sv
// Datapath of the interpolator core: table memories, binary search,
// interpolation multiply and restoring divide. Depends on riti_pkg.
module riti_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  riti_pkg::cmd_t                 cmd,
    output riti_pkg::sts_t                 sts,
    input  logic [1:0]                     in_mode,
    input  logic [riti_pkg::E_W-1:0]       in_energy,
    input  logic signed [riti_pkg::V_W-1:0] in_dec,
    input  logic signed [riti_pkg::V_W-1:0] in_abs,
    output logic [2:0]                     out_status,
    output logic signed [riti_pkg::V_W-1:0] out_real,
    output logic signed [riti_pkg::V_W-1:0] out_imag,
    output logic [riti_pkg::E_W-1:0]       out_emin,
    output logic [riti_pkg::E_W-1:0]       out_emax,
    output logic [riti_pkg::ENTRIES_W-1:0] out_entries
);
    import riti_pkg::*;

    logic [E_W-1:0]        mem_e [TABLE_DEPTH];
    logic signed [V_W-1:0] mem_d [TABLE_DEPTH];
    logic signed [V_W-1:0] mem_b [TABLE_DEPTH];

    logic [1:0]            mode_reg;
    logic [E_W-1:0]        e_reg;
    logic signed [V_W-1:0] dec_reg, abs_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [E_W-1:0]        lo_reg, hi_reg;
    logic [2:0]            status_reg;
    logic signed [V_W-1:0] re_reg, im_reg;

    // search window [lo, hi] over entries; result is first with energy >= e
    logic [ADDR_W:0]       slo_reg, shi_reg;
    logic [ADDR_W-1:0]     mid;
    logic [E_W-1:0]        rd_e_reg;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  mem_we;

    logic [E_W-1:0]        ep_reg, en_reg;
    logic signed [V_W-1:0] dp_reg, dn_reg, bp_reg, bn_reg;
    logic [E_W-1:0]        span_reg, t_reg;
    logic                  neg_d_reg, neg_b_reg;
    logic [MAG_W-1:0]      mag_d_reg, mag_b_reg;
    logic [PROD_W-1:0]     rem_d_reg, rem_b_reg;   // dividend shifting out
    logic [E_W-1:0]        pr_d_reg, pr_b_reg;     // partial remainders
    logic [MAG_W-1:0]      q_d_reg, q_b_reg;
    logic [6:0]            dcnt_reg;

    logic signed [V_W+1:0] diff_d, diff_b;
    logic [E_W:0]          trial_d, trial_b;
    logic signed [V_W+2:0] fin_d, fin_b, r_wide, i_wide;
    logic [2*E_W-1:0]      pl_d, pl_b;             // low partial products
    logic [MAG_W-1:0]      ph_d, ph_b;             // high partial products

    assign mid = ADDR_W'((slo_reg + shi_reg) >> 1);
    assign sts.query_direct = (mode_reg == MODE_QUERY) && (count_reg != '0) &&
                              (e_reg >= lo_reg) && (e_reg <= hi_reg);
    assign sts.srch_done = (slo_reg == shi_reg);
    assign sts.first_point = (slo_reg == '0);
    assign sts.div_done = (dcnt_reg == 7'd1);

    assign mem_we = cmd.decide && (mode_reg == MODE_LOAD) && (e_reg != '0) &&
                    !((count_reg != '0) && (e_reg <= hi_reg)) &&
                    (count_reg < CNT_W'(TABLE_DEPTH));

    always_comb begin
        rd_addr = mid;
        if (cmd.pair_rd) rd_addr = ADDR_W'(slo_reg - 1'b1);
        if (cmd.pair_lat) rd_addr = ADDR_W'(slo_reg);
        if (cmd.fin) rd_addr = '0;
    end

    // memories: one write port, one registered read port
    logic [E_W-1:0]        q_e;
    logic signed [V_W-1:0] q_dm, q_bm;
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_e[ADDR_W'(count_reg)] <= e_reg;
            mem_d[ADDR_W'(count_reg)] <= dec_reg;
            mem_b[ADDR_W'(count_reg)] <= abs_reg;
        end
        q_e  <= mem_e[rd_addr];
        q_dm <= mem_d[rd_addr];
        q_bm <= mem_b[rd_addr];
    end
    assign rd_e_reg = q_e;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            dcnt_reg  <= '0;
        end else begin
            if (cmd.decide) begin
                if (mem_we) begin
                    if (count_reg == '0) lo_reg <= e_reg;
                    hi_reg    <= e_reg;
                    count_reg <= count_reg + 1'b1;
                end else if (mode_reg == MODE_CLEAR) begin
                    count_reg <= '0;
                    lo_reg    <= '0;
                    hi_reg    <= '0;
                end
            end
            if (cmd.mul) dcnt_reg <= 7'(DIV_CYCLES);
            else if (cmd.div_step) dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    // product split into a 32 x 32 and an 18 x 32 part, low part first
    assign pl_d = mag_d_reg[E_W-1:0] * t_reg;
    assign pl_b = mag_b_reg[E_W-1:0] * t_reg;
    assign ph_d = mag_d_reg[MAG_W-1:E_W] * t_reg;
    assign ph_b = mag_b_reg[MAG_W-1:E_W] * t_reg;

    always_comb begin
        diff_d = (V_W+2)'(dn_reg) - (V_W+2)'(dp_reg);
        diff_b = (V_W+2)'(bn_reg) - (V_W+2)'(bp_reg);
        trial_d = {pr_d_reg, rem_d_reg[PROD_W-1]};
        trial_b = {pr_b_reg, rem_b_reg[PROD_W-1]};
        fin_d = neg_d_reg ? (V_W+3)'(dp_reg) - (V_W+3)'(signed'({1'b0, q_d_reg}))
                          : (V_W+3)'(dp_reg) + (V_W+3)'(signed'({1'b0, q_d_reg}));
        fin_b = neg_b_reg ? (V_W+3)'(bp_reg) - (V_W+3)'(signed'({1'b0, q_b_reg}))
                          : (V_W+3)'(bp_reg) + (V_W+3)'(signed'({1'b0, q_b_reg}));
        if (sts.first_point) begin
            fin_d = (V_W+3)'(q_dm);
            fin_b = (V_W+3)'(q_bm);
        end
        r_wide = (V_W+3)'(signed'({1'b0, 41'h100_0000_0000})) - fin_d;
        i_wide = -fin_b;
    end

    function automatic logic signed [V_W-1:0] sat(input logic signed [V_W+2:0] v);
        if (v > (V_W+3)'(signed'({1'b0, {(V_W-1){1'b1}}}))) return {1'b0, {(V_W-1){1'b1}}};
        if (v < -(V_W+3)'(signed'({1'b0, 1'b1, {(V_W-1){1'b0}}})))
            return {1'b1, {(V_W-1){1'b0}}};
        return V_W'(v);
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg <= in_mode;
            e_reg    <= in_energy;
            dec_reg  <= in_dec;
            abs_reg  <= in_abs;
        end
        if (cmd.decide) begin
            re_reg <= '0;
            im_reg <= '0;
            status_reg <= ST_OK;
            case (mode_reg)
                MODE_LOAD: begin
                    if (e_reg == '0) status_reg <= ST_ZERO;
                    else if ((count_reg != '0) && (e_reg <= hi_reg)) status_reg <= ST_NOT_INCR;
                    else if (count_reg >= CNT_W'(TABLE_DEPTH)) status_reg <= ST_FULL;
                end
                MODE_QUERY: begin
                    if (count_reg == '0) status_reg <= ST_EMPTY;
                    else if ((e_reg < lo_reg) || (e_reg > hi_reg)) status_reg <= ST_RANGE;
                end
                default: status_reg <= ST_OK;
            endcase
        end
        if (cmd.srch_init) begin
            slo_reg <= '0;
            shi_reg <= (ADDR_W+1)'(count_reg - 1'b1);
        end
        if (cmd.srch_cmp && !sts.srch_done) begin
            if (rd_e_reg < e_reg) slo_reg <= (ADDR_W+1)'(mid) + 1'b1;
            else shi_reg <= (ADDR_W+1)'(mid);
        end
        if (cmd.pair_lat) begin
            ep_reg <= q_e;
            dp_reg <= q_dm;
            bp_reg <= q_bm;
        end
        if (cmd.mul) begin
            en_reg <= q_e;
            dn_reg <= q_dm;
            bn_reg <= q_bm;
        end
        if (cmd.fin) begin
            re_reg <= sat(r_wide);
            im_reg <= sat(i_wide);
        end
    end

    // set up operands, low and high partial products in turn, then one restoring step per product bit
    always_ff @(posedge aclk) begin
        if (cmd.div_step) begin
            if (dcnt_reg == 7'(DIV_CYCLES)) begin
                neg_d_reg <= diff_d[V_W+1];
                neg_b_reg <= diff_b[V_W+1];
                mag_d_reg <= diff_d[V_W+1] ? MAG_W'(-diff_d) : MAG_W'(diff_d);
                mag_b_reg <= diff_b[V_W+1] ? MAG_W'(-diff_b) : MAG_W'(diff_b);
                t_reg    <= e_reg - ep_reg;
                span_reg <= en_reg - ep_reg;
                pr_d_reg <= '0;
                pr_b_reg <= '0;
                q_d_reg  <= '0;
                q_b_reg  <= '0;
            end else if (dcnt_reg == 7'(DIV_CYCLES - 1)) begin
                rem_d_reg <= PROD_W'(pl_d);
                rem_b_reg <= PROD_W'(pl_b);
            end else if (dcnt_reg == 7'(DIV_CYCLES - 2)) begin
                rem_d_reg <= rem_d_reg + {ph_d, {E_W{1'b0}}};
                rem_b_reg <= rem_b_reg + {ph_b, {E_W{1'b0}}};
            end else begin
                rem_d_reg <= rem_d_reg << 1;
                rem_b_reg <= rem_b_reg << 1;
                if (trial_d >= {1'b0, span_reg}) begin
                    pr_d_reg <= E_W'(trial_d - {1'b0, span_reg});
                    q_d_reg <= {q_d_reg[MAG_W-2:0], 1'b1};
                end else begin
                    pr_d_reg <= E_W'(trial_d);
                    q_d_reg <= {q_d_reg[MAG_W-2:0], 1'b0};
                end
                if (trial_b >= {1'b0, span_reg}) begin
                    pr_b_reg <= E_W'(trial_b - {1'b0, span_reg});
                    q_b_reg <= {q_b_reg[MAG_W-2:0], 1'b1};
                end else begin
                    pr_b_reg <= E_W'(trial_b);
                    q_b_reg <= {q_b_reg[MAG_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_status  = status_reg;
    assign out_real    = re_reg;
    assign out_imag    = im_reg;
    assign out_emin    = lo_reg;
    assign out_emax    = hi_reg;
    assign out_entries = ENTRIES_W'(count_reg);

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond depth");
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |=> (hi_reg == $past(e_reg)))
        else $error("highest energy not tracked");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.srch_cmp |-> slo_reg <= shi_reg)
        else $error("search window inverted");

endmodule

// File: rtl/core/refraction_index_table_interpolator_core.sv
// Top level of the refraction index table interpolator core.
// Depends on riti_pkg, riti_ctrl and riti_dp.
//
// Channel | Direction | Beat contents
// s_      | in        | tuser = mode[1:0]; tdata = energy, decrement, absorption
// m_      | out       | tdata = status, index_real, index_imag, energy_min,
//         |           |         energy_max, entries
//
// Loads, clears, unused-mode and refused items go from idle through decide to the
// result beat (idle, decide, result). A query in range adds the binary search read and
// compare passes and a finishing state; interpolation adds the pair-read states (pair
// read, pair latch, multiply) and the divider (set-up of operands and partial products,
// then 82 restoring steps for the 82-bit product).
// aresetn (synchronous, active low) empties the table; no clearing pass is needed.
// One item is in flight: s_tready holds low until the result beat is taken.
module refraction_index_table_interpolator_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // energy[31:0], decrement[79:32], absorption[127:80]
    input  logic [1:0]   s_tuser,  // mode[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [175:0] m_tdata   // status[2:0], index_real[50:3], index_imag[98:51],
                                   // energy_min[130:99], energy_max[162:131],
                                   // entries[172:163], zero fill above
);
    import riti_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic [2:0]            st;
    logic signed [V_W-1:0] re, im;
    logic [E_W-1:0]        emin, emax;
    logic [ENTRIES_W-1:0]  ent;

    riti_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .out_ready(m_tready), .sts(sts), .cmd(cmd)
    );

    riti_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .in_mode(s_tuser), .in_energy(s_tdata[31:0]),
        .in_dec(s_tdata[79:32]), .in_abs(s_tdata[127:80]),
        .out_status(st), .out_real(re), .out_imag(im),
        .out_emin(emin), .out_emax(emax), .out_entries(ent)
    );

    // hold the result beat until taken
    assign m_tvalid = cmd.out_valid;
    assign m_tdata  = {3'd0, ent, emax, emin, im, re, st};

endmodule

// File: test/testbench.sv
// Self-checking testbench for refraction_index_table_interpolator_core.
// Depends on riti_pkg and the core; predicts each result beat from its own table model.
`timescale 1ns / 100ps

module testbench;
    import riti_pkg::*;

    localparam int    LIMIT_CYCLES = 1500000;
    localparam longint MAX_V = 64'sh7FFF_FFFF_FFFF;
    localparam longint MIN_V = -64'sh8000_0000_0000;
    localparam longint ONE_V = 64'sh100_0000_0000;

    // highest field first, so status lands in the lowest bits
    typedef struct packed {
        logic [9:0]  entries;
        logic [31:0] emax;
        logic [31:0] emin;
        logic [47:0] im;
        logic [47:0] re;
        logic [2:0]  status;
    } index_beat_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;   // energy[31:0], decrement[79:32], absorption[127:80]
    logic [1:0]   s_tuser = '0;   // mode[1:0]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [175:0] m_tdata;        // status, index_real, index_imag, energy_min,
                                  // energy_max, entries, zero fill above

    // Shadow copy of the table
    logic [31:0]  tbl_energy [TABLE_DEPTH];
    longint       tbl_delta  [TABLE_DEPTH];
    longint       tbl_beta   [TABLE_DEPTH];
    int           tbl_count;
    logic [31:0]  tbl_lo, tbl_hi;

    index_beat_t  pending_index[$];
    int           mismatches = 0;
    longint       cycle_count = 0;
    bit           sink_hold;      // long hold-off of the result side
    bit           calm;           // no idling in the last part

    refraction_index_table_interpolator_core dut (.*);

    always #2 aclk = ~aclk;

    // Exact interpolation: prev + (next - prev) * t / span, truncated toward zero
    function automatic longint lerp_point(longint prev, longint nxt, logic [31:0] t,
                                          logic [31:0] span);
        logic signed [127:0] diff;
        logic [127:0]        mag;
        logic [127:0]        q;
        diff = nxt - prev;
        mag  = diff < 0 ? -diff : diff;
        q    = (mag * t) / span;
        return diff < 0 ? prev - longint'(q) : prev + longint'(q);
    endfunction

    function automatic longint clamp48(longint v);
        return v > MAX_V ? MAX_V : (v < MIN_V ? MIN_V : v);
    endfunction

    // Advance the shadow table by one item and return the beat it causes
    function automatic index_beat_t table_step(mode_t mode, logic [31:0] e,
                                               logic [47:0] dlt, logic [47:0] bta);
        index_beat_t r;
        int          i;
        longint      d, b;
        r = '0;
        if (mode == MODE_LOAD) begin
            if (e == 0) begin
                r.status = ST_ZERO;
            end else if (tbl_count > 0 && e <= tbl_energy[tbl_count-1]) begin
                r.status = ST_NOT_INCR;
            end else if (tbl_count >= TABLE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                tbl_energy[tbl_count] = e;
                tbl_delta[tbl_count]  = longint'(signed'(dlt));
                tbl_beta[tbl_count]   = longint'(signed'(bta));
                if (tbl_count == 0) tbl_lo = e;
                tbl_hi = e;
                tbl_count++;
            end
        end else if (mode == MODE_QUERY) begin
            if (tbl_count == 0) begin
                r.status = ST_EMPTY;
            end else if (e < tbl_lo || e > tbl_hi) begin
                r.status = ST_RANGE;
            end else begin
                i = 0;
                while (i < tbl_count - 1 && tbl_energy[i] < e) i++;
                if (i == 0) begin
                    d = tbl_delta[0];
                    b = tbl_beta[0];
                end else begin
                    d = lerp_point(tbl_delta[i-1], tbl_delta[i], e - tbl_energy[i-1],
                                   tbl_energy[i] - tbl_energy[i-1]);
                    b = lerp_point(tbl_beta[i-1], tbl_beta[i], e - tbl_energy[i-1],
                                   tbl_energy[i] - tbl_energy[i-1]);
                end
                r.re = 48'(clamp48(ONE_V - d));
                r.im = 48'(clamp48(-b));
            end
        end else if (mode == MODE_CLEAR) begin
            tbl_count = 0;
            tbl_lo = 0;
            tbl_hi = 0;
        end
        r.emin    = tbl_lo;
        r.emax    = tbl_hi;
        r.entries = tbl_count[9:0];
        return r;
    endfunction

    // Offer one beat, with an optional idle burst first; predict on acceptance
    task automatic send_item(mode_t mode, logic [31:0] e, logic [47:0] dlt = '0,
                             logic [47:0] bta = '0);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {bta, dlt, e};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_index.push_back(table_step(mode, e, dlt, bta));
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_index.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    // Directed: refusals, empty/range flags, exact points, saturation, mode 3
    task automatic test_directed();
        send_item(MODE_QUERY, 32'd100);
        send_item(MODE_LOAD, 32'd0, 48'h1, 48'h1);
        send_item(MODE_LOAD, 32'd1, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
        send_item(MODE_LOAD, 32'd1, 48'h0, 48'h0);
        send_item(MODE_QUERY, 32'd1);
        send_item(MODE_LOAD, 32'hFFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF);
        send_item(MODE_LOAD, 32'hFFFF_FFFF, 48'h0, 48'h0);
        send_item(MODE_QUERY, 32'h8000_0000);
        send_item(MODE_QUERY, 32'hFFFF_FFFF);
        send_item(MODE_QUERY, 32'h0);
        send_item(MODE_QUERY, 32'h7FFF_FFFF);
        send_item(MODE_NONE, 32'h1234, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_item(MODE_CLEAR, 32'h5);
        send_item(MODE_QUERY, 32'h5);
        send_item(MODE_LOAD, 32'h10, 48'h0, 48'hFFFF_FFFF_FFFF);
        send_item(MODE_QUERY, 32'h10);
        send_item(MODE_QUERY, 32'h11);
        send_item(MODE_QUERY, 32'hF);
    endtask

    // Fill to capacity, then refuse once full, and query across the whole table
    task automatic test_full_table();
        logic [31:0] e;
        send_item(MODE_CLEAR, '0);
        e = 32'd0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            e += $urandom_range(1, 2000);
            send_item(MODE_LOAD, e, rand48(), rand48());
        end
        send_item(MODE_LOAD, e + 1, rand48(), rand48());
        send_item(MODE_LOAD, 32'hFFFF_FFFF, rand48(), rand48());
        for (int k = 0; k < 40; k++) send_item(MODE_QUERY, $urandom_range(0, e + 5));
    endtask

    // Random: mostly well-formed tables of random length, queried mostly inside the range
    task automatic test_random_tables(int n_items);
        int          sent, len, step;
        logic [31:0] e;
        sent = 0;
        while (sent < n_items) begin
            send_item(MODE_CLEAR, $urandom);
            sent++;
            len  = $urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : $urandom_range(2, 30);
            step = $urandom_range(0, 1) ? 20 : 32'h0800_0000;
            e    = $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : $urandom_range(1, 1000);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(MODE_LOAD, $urandom_range(0, 4) == 0 ? 0 : e,
                              rand48(), rand48());
                else
                    send_item(MODE_LOAD, e, rand48(), rand48());
                e += $urandom_range(1, step);
                sent++;
            end
            for (int k = 0; k < len * 2; k++) begin
                case ($urandom_range(0, 9))
                    0: send_item(MODE_QUERY, $urandom);
                    1: send_item(MODE_NONE, $urandom, rand48(), rand48());
                    default: send_item(MODE_QUERY,
                                       $urandom_range(tbl_lo, tbl_hi == 0 ? 0 : tbl_hi));
                endcase
                sent++;
            end
        end
    endtask

    // Hold the result side off for a long stretch while items keep coming
    task automatic test_backpressure();
        sink_hold = 1'b1;
        fork
            begin
                for (int k = 0; k < 6; k++)
                    send_item(MODE_QUERY, $urandom_range(tbl_lo, tbl_hi));
            end
            begin
                repeat (300) @(negedge aclk);
                sink_hold = 1'b0;
            end
        join
    endtask

    // Result side: random stall bursts, sample and compare at the rising edge
    always @(negedge aclk) begin
        if (sink_hold) begin
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge aclk);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        index_beat_t got, want;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[172:0];
            if (pending_index.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
            end else begin
                want = pending_index.pop_front();
                if (got !== want || m_tdata[175:173] !== '0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: status %0d/%0d re %h/%h im %h/%h",
                                  " min %h/%h max %h/%h n %0d/%0d"},
                                 want.status, got.status, want.re, got.re, want.im, got.im,
                                 want.emin, got.emin, want.emax, got.emax,
                                 want.entries, got.entries);
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge aclk) begin
        if (cycle_count > LIMIT_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        sink_hold   = 1'b0;
        calm        = 1'b0;
        tbl_count   = 0;
        tbl_lo      = 0;
        tbl_hi      = 0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_full_table();
        test_backpressure();
        test_random_tables(1050);
        calm = 1'b1;
        test_random_tables(200);
        drain();
        if (mismatches == 0 && pending_index.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
